// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL.
// All checks are sampled on clk_i and are off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true at a sampled edge.
`define ASSERT_NEVER(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`endif

// ----- design/wrms_pkg.sv -----
package wrms_pkg;

  // Payload widths of the element and result channels
  localparam int unsigned XWidth    = 24;  // signed Q7.16 element
  localparam int unsigned WWidth    = 24;  // unsigned Q8.16 weight
  localparam int unsigned NormWidth = 32;  // unsigned Q16.16 result

  // Datapath widths
  localparam int unsigned MulWidth  = 32;  // shared multiplier operand width
  localparam int unsigned SumWidth  = 64;  // sum of squares, 32 fraction bits

  // Truncation of x*w from 32 to 16 fraction bits
  localparam int unsigned FracDrop  = 16;

endpackage

// ----- design/wrms_if.sv -----
// Element channel: one vector element per transfer
interface wrms_in_if import wrms_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [XWidth-1:0] x_value;
  logic        [WWidth-1:0] weight;
  logic                     last;

  modport source (output valid, x_value, weight, last, input ready);
  modport sink   (input valid, x_value, weight, last, output ready);
endinterface

// Result channel: one norm per vector
interface wrms_out_if import wrms_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [NormWidth-1:0] norm;
  logic                 overflow;

  modport source (output valid, norm, overflow, input ready);
  modport sink   (input valid, norm, overflow, output ready);
endinterface

// ----- design/weighted_rms_norm.sv -----
// Weighted RMS norm over a stream of vector elements.
// in_i carries one element per transfer: x_value (signed Q7.16), weight
// (unsigned Q8.16) and last. out_o carries one result per vector: norm =
// floor(sqrt(sum((x*w)^2) / n)) in Q16.16, and overflow when the sum of
// squares saturated at its 64-bit ceiling.
// Each element runs through product, rounding, square and accumulate on one
// shared 32x32 multiplier and one shared 64-bit adder. in_i.ready is high
// only in the idle state, so a new element is not taken before the previous
// one is accumulated. After the last element the same adder runs a restoring
// divide by the element count and then a bit-pair square root; the result
// then goes to out_o once the output register is free.
// The count holds at MAX_LENGTH; longer vectors still add to the sum.
// The result waits in an output register, so the next vector may start while
// out_o is stalled; only a second result waits for the first to be taken.
// Reset (rst_ni low, asynchronous) clears the sum, count, overflow flag,
// the sequencer and the output valid.
module weighted_rms_norm import wrms_pkg::*; #(
  parameter int unsigned MAX_LENGTH = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wrms_in_if.sink    in_i,
  wrms_out_if.source out_o
);

`include "assert_macros.svh"

  localparam int unsigned CntW = $clog2(MAX_LENGTH + 1);

  localparam logic [SumWidth-1:0] SqrtBitInit = {2'b01, {(SumWidth-2){1'b0}}};
  localparam logic [SumWidth-1:0] RoundAdd    = {{(SumWidth-FracDrop){1'b0}},
                                                 {FracDrop{1'b1}}};

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL1 = 8'b0000_0010,
    S_RND  = 8'b0000_0100,
    S_SQR  = 8'b0000_1000,
    S_ACC  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_SQRT = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e                state_q, state_d;
  logic [SumWidth-1:0]   sum_q, sum_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  sat_q, sat_d;
  logic                  out_valid_q, out_valid_d;

  logic [XWidth-1:0]     xmag_q, xmag_d;
  logic                  neg_q, neg_d;
  logic [WWidth-1:0]     w_q, w_d;
  logic                  last_q, last_d;
  logic [SumWidth-1:0]   prod_q, prod_d;
  logic [MulWidth-1:0]   qmag_q, qmag_d;
  logic [SumWidth-1:0]   num_q, num_d;
  logic [CntW-1:0]       rem_q, rem_d;
  logic [SumWidth-1:0]   res_q, res_d;
  logic [SumWidth-1:0]   bit_q, bit_d;
  logic [5:0]            step_q, step_d;
  logic [NormWidth-1:0]  norm_q, norm_d;
  logic                  ovf_q, ovf_d;

  // Shared multiplier
  logic [MulWidth-1:0]   mul_a, mul_b;
  logic [SumWidth-1:0]   mul_p;

  // Shared adder / subtractor
  logic [SumWidth-1:0]   add_a, add_b;
  logic                  add_sub;
  logic [SumWidth:0]     add_r;
  logic                  add_c;

  logic [CntW:0]         rsh;
  logic                  out_free;

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.norm     = norm_q;
  assign out_o.overflow = ovf_q;

  assign out_free = !out_valid_q || out_o.ready;
  assign rsh      = {rem_q, num_q[SumWidth-1]};

  // Multiplier operand select
  always_comb begin
    if (state_q == S_SQR) begin
      mul_a = qmag_q;
      mul_b = qmag_q;
    end else begin
      mul_a = MulWidth'(xmag_q);
      mul_b = MulWidth'(w_q);
    end
  end
  assign mul_p = mul_a * mul_b;

  // Adder operand select; carry out is overflow on add, a >= b on subtract
  always_comb begin
    add_a   = sum_q;
    add_b   = prod_q;
    add_sub = 1'b0;
    unique case (state_q)
      S_RND: begin
        add_a = prod_q;
        add_b = neg_q ? RoundAdd : '0;
      end
      S_DIV: begin
        add_a   = SumWidth'(rsh);
        add_b   = SumWidth'(cnt_q);
        add_sub = 1'b1;
      end
      S_SQRT: begin
        add_a   = num_q;
        add_b   = res_q | bit_q;
        add_sub = 1'b1;
      end
      default: begin
        add_a   = sum_q;
        add_b   = prod_q;
        add_sub = 1'b0;
      end
    endcase
  end
  assign add_r = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} +
                 {{SumWidth{1'b0}}, add_sub};
  assign add_c = add_r[SumWidth];

  // Sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q;
    xmag_d      = xmag_q;
    neg_d       = neg_q;
    w_d         = w_q;
    last_d      = last_q;
    prod_d      = prod_q;
    qmag_d      = qmag_q;
    num_d       = num_q;
    rem_d       = rem_q;
    res_d       = res_q;
    bit_d       = bit_q;
    step_d      = step_q;
    norm_d      = norm_q;
    ovf_d       = ovf_q;

    // result taken by the receiver
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          neg_d   = in_i.x_value[XWidth-1];
          xmag_d  = in_i.x_value[XWidth-1] ? (~in_i.x_value + 1'b1) : in_i.x_value;
          w_d     = in_i.weight;
          last_d  = in_i.last;
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        prod_d  = mul_p;
        state_d = S_RND;
      end
      S_RND: begin
        // floor(x*w / 2^16) in magnitude form: round the magnitude up if negative
        qmag_d  = add_r[FracDrop +: MulWidth];
        state_d = S_SQR;
      end
      S_SQR: begin
        prod_d  = mul_p;
        state_d = S_ACC;
      end
      S_ACC: begin
        if (add_c) begin
          sum_d = '1;
          sat_d = 1'b1;
        end else begin
          sum_d = add_r[SumWidth-1:0];
        end
        if (cnt_q < CntW'(MAX_LENGTH)) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (last_q) begin
          num_d   = add_c ? '1 : add_r[SumWidth-1:0];
          rem_d   = '0;
          step_d  = '1;
          state_d = S_DIV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        rem_d = add_c ? add_r[CntW-1:0] : rsh[CntW-1:0];
        num_d = {num_q[SumWidth-2:0], add_c};
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          res_d   = '0;
          bit_d   = SqrtBitInit;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        // one root bit per cycle; res + bit never carries, so OR is enough
        if (add_c) begin
          num_d = add_r[SumWidth-1:0];
          res_d = (res_q >> 1) | bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          norm_d      = res_q[NormWidth-1:0];
          ovf_d       = sat_q;
          out_valid_d = 1'b1;
          sum_d       = '0;
          cnt_d       = '0;
          sat_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    xmag_q <= xmag_d;
    neg_q  <= neg_d;
    w_q    <= w_d;
    last_q <= last_d;
    prod_q <= prod_d;
    qmag_q <= qmag_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    step_q <= step_d;
    norm_q <= norm_d;
    ovf_q  <= ovf_d;
  end

  // Checks
  `ASSERT_CLK(a_cnt_bound, cnt_q <= CntW'(MAX_LENGTH), "element count above MAX_LENGTH")
  `ASSERT_CLK(a_div_nonzero, (state_q == S_ACC && last_q) |=> (state_q == S_DIV && cnt_q != '0), "divide started with zero count")
  `ASSERT_CLK(a_sqrt_init, (state_q == S_DIV && step_q == '0) |=> (state_q == S_SQRT && bit_q == SqrtBitInit && res_q == '0), "root not set up after divide")
  `ASSERT_NEVER(a_no_overwrite, state_q == S_DONE && out_valid_q && !out_o.ready && state_d != S_DONE, "pending result overwritten")

endmodule

// ----- sim/wrms_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels of weighted_rms_norm, predicts the norm of every
// vector from the accepted elements and compares it with the result transfers.
module wrms_checker import wrms_pkg::*; #(
  parameter int unsigned MAX_LENGTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wrms_in_if          elem_i,
  wrms_out_if         norm_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  localparam int unsigned CountWidth = $clog2(MAX_LENGTH + 1);

  typedef struct packed {
    logic [NormWidth-1:0] norm;
    logic                 overflow;
  } norm_result_t;

  // Norms predicted but not yet seen on the result channel, oldest first
  norm_result_t expected_norms[$];

  // Running state of the vector being accumulated
  logic [SumWidth-1:0]   square_sum;
  logic [CountWidth-1:0] element_count;
  logic                  saturated;

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    logic signed [XWidth+WWidth:0]          product;
    logic signed [XWidth+WWidth-FracDrop:0] scaled;
    logic [MulWidth-1:0]                    magnitude;
    logic [SumWidth-1:0]                    square;
    logic [SumWidth:0]                      total;
    logic [SumWidth-1:0]                    mean;
    logic [SumWidth-1:0]                    trial;
    logic [SumWidth-1:0]                    root;
    norm_result_t                           want;
    int unsigned                            fails;
    if (!rst_ni) begin
      expected_norms.delete();
      square_sum    = '0;
      element_count = '0;
      saturated     = 1'b0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      fails = fail_count_o;

      // Result transfer: compare with the oldest prediction
      if (norm_i.valid && norm_i.ready) begin
        if (expected_norms.size() == 0) begin
          $error("unexpected result: norm %0h overflow %0b", norm_i.norm, norm_i.overflow);
          fails++;
        end else begin
          want = expected_norms.pop_front();
          if (norm_i.norm !== want.norm) begin
            $error("norm: expected %0h, actual %0h", want.norm, norm_i.norm);
            fails++;
          end
          if (norm_i.overflow !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow, norm_i.overflow);
            fails++;
          end
        end
      end

      // Element transfer: floor(x*w) in Q15.16, squared into the saturating sum
      if (elem_i.valid && elem_i.ready) begin
        product   = elem_i.x_value * $signed({1'b0, elem_i.weight});
        scaled    = product >>> FracDrop;
        magnitude = scaled[$high(scaled)] ? MulWidth'(-scaled) : MulWidth'(scaled);
        square    = SumWidth'(magnitude) * SumWidth'(magnitude);
        total     = {1'b0, square_sum} + {1'b0, square};
        if (total[SumWidth]) begin
          square_sum = '1;
          saturated  = 1'b1;
        end else begin
          square_sum = total[SumWidth-1:0];
        end
        // count sticks at the maximum length; the sum keeps growing
        if (element_count < MAX_LENGTH) begin
          element_count++;
        end

        if (elem_i.last) begin
          mean = square_sum / SumWidth'(element_count);
          // bitwise integer square root, MSB first
          root = '0;
          for (int b = NormWidth - 1; b >= 0; b--) begin
            trial = root | (SumWidth'(1) << b);
            if (trial * trial <= mean) begin
              root = trial;
            end
          end
          expected_norms.push_back('{norm: root[NormWidth-1:0], overflow: saturated});
          square_sum    = '0;
          element_count = '0;
          saturated     = 1'b0;
        end
      end

      pending_o    <= expected_norms.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import wrms_pkg::*;

  localparam int unsigned MaxLength   = 4096;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 150;

  localparam logic signed [XWidth-1:0] XMax = {1'b0, {(XWidth-1){1'b1}}};
  localparam logic signed [XWidth-1:0] XMin = {1'b1, {(XWidth-1){1'b0}}};
  localparam logic [WWidth-1:0]        WMax = '1;
  localparam logic [WWidth-1:0]        WOne = WWidth'(1) << FracDrop;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned source_gap_pct = 17;
  int unsigned sink_stall_pct = 55;
  int unsigned cycle_count    = 0;
  int unsigned pending_norms;
  int unsigned fail_count;

  wrms_in_if  elem_if ();
  wrms_out_if norm_if ();

  weighted_rms_norm #(
    .MAX_LENGTH(MaxLength)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (elem_if.sink),
    .out_o (norm_if.source)
  );

  wrms_checker #(
    .MAX_LENGTH(MaxLength)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .elem_i      (elem_if),
    .norm_i      (norm_if),
    .pending_o   (pending_norms),
    .fail_count_o(fail_count)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result receiver stalls at random
  always @(posedge clk_i) begin
    norm_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One element transfer, after a random number of idle cycles
  task automatic push_element(input logic signed [XWidth-1:0] x, input logic [WWidth-1:0] w,
                              input logic last);
    while ($urandom_range(99) < source_gap_pct) begin
      elem_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    elem_if.valid   <= 1'b1;
    elem_if.x_value <= x;
    elem_if.weight  <= w;
    elem_if.last    <= last;
    do @(posedge clk_i); while (!elem_if.ready);
  endtask

  // Hold off the sender until every predicted norm has been taken
  task automatic wait_drained();
    elem_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_norms != 0) @(posedge clk_i);
  endtask

  // Random vectors: mostly short, some long; a quarter near full scale so
  // that the sum can saturate
  task automatic random_vectors(input int unsigned item_target);
    int unsigned              sent;
    int unsigned              len;
    bit                       heavy;
    logic signed [XWidth-1:0] x;
    logic [WWidth-1:0]        w;
    sent = 0;
    while (sent < item_target) begin
      len   = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      heavy = ($urandom_range(3) == 0);
      for (int i = 0; i < len; i++) begin
        if (heavy) begin
          x = $urandom_range(1) ? XWidth'(XMin + $urandom_range(255))
                                : XWidth'(XMax - $urandom_range(255));
          w = WWidth'(WMax - $urandom_range(65535));
        end else begin
          x = XWidth'($urandom);
          w = ($urandom_range(15) == 0) ? '0 : WWidth'($urandom);
        end
        push_element(x, w, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    elem_if.valid   = 1'b0;
    elem_if.x_value = '0;
    elem_if.weight  = '0;
    elem_if.last    = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Single elements at the field extremes, rounding of negative products
    push_element('0, '0, 1'b1);
    push_element(XMax, WMax, 1'b1);
    push_element(XMin, WMax, 1'b1);
    push_element(XMax, WWidth'(1), 1'b1);
    push_element(XMin, WWidth'(1), 1'b1);
    push_element(-1, WWidth'(1), 1'b1);
    push_element(1, WWidth'(1), 1'b1);
    push_element(-1, WOne, 1'b1);
    // zero weight still counts
    push_element(XMax, '0, 1'b0);
    push_element(XWidth'(WOne), WOne, 1'b1);
    // sum saturation, then a clean vector to see the flag cleared
    repeat (5) push_element(XMin, WMax, 1'b0);
    push_element(XMax, WMax, 1'b1);
    push_element(XWidth'(WOne), WOne, 1'b1);
    wait_drained();

    // Random vectors under three idling patterns
    random_vectors(150);
    wait_drained();
    source_gap_pct <= 55;
    sink_stall_pct <= 17;
    random_vectors(150);
    wait_drained();
    source_gap_pct <= 0;
    sink_stall_pct <= 0;
    random_vectors(150);
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
